@@ src/usteer_pkg.sv @@
// Shared types, constants and codes for the ultrasonic obstacle steering block.
`timescale 1ns / 1ps

package usteer_pkg;

  // Capture counter and result widths
  localparam int COUNT_BITS = 16;
  localparam int CH_W       = 2;
  localparam int DIST_W     = 21;
  localparam int DUTY_W     = 12;
  localparam int MODE_W     = 3;
  localparam int BRIDGE_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int NUM_CH     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CRUISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW    = 3'd4;

  // Channel codes
  localparam logic [CH_W-1:0] CH_FRONT       = 2'd0;
  localparam logic [CH_W-1:0] CH_REAR        = 2'd1;
  localparam logic [CH_W-1:0] CH_FRONT_RIGHT = 2'd2;
  localparam logic [CH_W-1:0] CH_FRONT_LEFT  = 2'd3;

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_STOP        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORWARD     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACK        = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SLOW_RIGHT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUICK_RIGHT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SLOW_LEFT   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_QUICK_LEFT  = 3'd6;

  // H-bridge codes, IN1 in the top bit
  localparam logic [BRIDGE_W-1:0] BRIDGE_STOP    = 4'b1111;
  localparam logic [BRIDGE_W-1:0] BRIDGE_FORWARD = 4'b1010;
  localparam logic [BRIDGE_W-1:0] BRIDGE_BACK    = 4'b0101;
  localparam logic [BRIDGE_W-1:0] BRIDGE_QRIGHT  = 4'b1001;
  localparam logic [BRIDGE_W-1:0] BRIDGE_QLEFT   = 4'b0110;

  // Register reset values
  localparam logic [COUNT_BITS-1:0] RST_COUNTER_TOP = 16'd65534;
  localparam logic [DIST_W-1:0]     RST_NEAR_LIMIT  = 21'd10000;
  localparam logic [DUTY_W-1:0]     RST_DUTY_CRUISE = 12'd1400;
  localparam logic [DUTY_W-1:0]     RST_DUTY_HIGH   = 12'd1600;
  localparam logic [DUTY_W-1:0]     RST_DUTY_LOW    = 12'd1300;

  // Measured pulse handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]       ch;
    logic [COUNT_BITS-1:0] width;
  } pulse_t;

  // Steering settings used by the back end
  typedef struct packed {
    logic [DIST_W-1:0] near_limit;
    logic [DUTY_W-1:0] duty_cruise;
    logic [DUTY_W-1:0] duty_high;
    logic [DUTY_W-1:0] duty_low;
  } steer_cfg_t;

endpackage

@@ src/usteer_front.sv @@
// Edge tracking per channel and pulse width measurement with wrap correction.
`timescale 1ns / 1ps

module usteer_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [usteer_pkg::CH_W-1:0]      in_channel,
  input  logic [usteer_pkg::COUNT_BITS-1:0] in_capture_count,
  input  logic [usteer_pkg::COUNT_BITS-1:0] counter_top,
  output logic                             push,
  output usteer_pkg::pulse_t               push_data
);
  import usteer_pkg::*;

  logic [NUM_CH-1:0]     awaiting_fall_r;
  logic [NUM_CH-1:0]     awaiting_fall_nxt;
  logic [COUNT_BITS-1:0] rise_stamp_r [NUM_CH];
  logic                  accept;
  logic                  is_fall;
  logic [COUNT_BITS-1:0] t1;
  logic [COUNT_BITS:0]   wrap_sum;
  logic [COUNT_BITS:0]   wrap_width;
  logic [COUNT_BITS-1:0] width;

  assign accept = in_valid && !in_stall;
  assign is_fall = awaiting_fall_r[in_channel];
  assign t1 = rise_stamp_r[in_channel];

  // Width of the pulse, wrapping through counter_top when the count rolled over
  always_comb begin
    wrap_sum   = {1'b0, counter_top} + {1'b0, in_capture_count} + {{COUNT_BITS{1'b0}}, 1'b1};
    wrap_width = wrap_sum - {1'b0, t1};
    if (in_capture_count > t1) begin
      width = in_capture_count - t1;
    end else if (wrap_sum < {1'b0, t1}) begin
      width = '0;
    end else if (wrap_width[COUNT_BITS]) begin
      width = '1;
    end else begin
      width = wrap_width[COUNT_BITS-1:0];
    end
  end

  assign push = accept && is_fall;
  assign push_data.ch = in_channel;
  assign push_data.width = width;

  // Toggle the edge phase of the channel on every transfer
  always_comb begin
    awaiting_fall_nxt = awaiting_fall_r;
    if (accept) begin
      awaiting_fall_nxt[in_channel] = !is_fall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_fall_r <= '0;
    end else begin
      awaiting_fall_r <= awaiting_fall_nxt;
    end
  end

  // Store the rising-edge stamp
  always_ff @(posedge clk) begin
    if (accept && !is_fall) begin
      rise_stamp_r[in_channel] <= in_capture_count;
    end
  end

endmodule

@@ src/usteer_fifo.sv @@
// Two-entry queue of measured pulses between front and back end.
`timescale 1ns / 1ps

module usteer_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  usteer_pkg::pulse_t push_data,
  input  logic               pop,
  output usteer_pkg::pulse_t pop_data,
  output logic               not_empty,
  output logic               full
);
  import usteer_pkg::*;

  pulse_t     mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/usteer_back.sv @@
// Distance scaling, obstacle priority rule and drive output register.
`timescale 1ns / 1ps

module usteer_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  usteer_pkg::steer_cfg_t           cfg,
  input  logic                             q_not_empty,
  input  usteer_pkg::pulse_t               q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [usteer_pkg::CH_W-1:0]      out_measured_channel,
  output logic [usteer_pkg::DIST_W-1:0]    out_distance,
  output logic [usteer_pkg::MODE_W-1:0]    out_drive_mode,
  output logic [usteer_pkg::BRIDGE_W-1:0]  out_bridge_bits,
  output logic [usteer_pkg::DUTY_W-1:0]    out_duty_left,
  output logic [usteer_pkg::DUTY_W-1:0]    out_duty_right
);
  import usteer_pkg::*;

  localparam int PROD_W = COUNT_BITS + 5;

  logic [DIST_W-1:0]   last_distance_r [NUM_CH];
  logic [DUTY_W-1:0]   held_duty_a_r;
  logic [DUTY_W-1:0]   held_duty_b_r;
  logic                out_valid_r;
  logic [CH_W-1:0]     ch_r;
  logic [DIST_W-1:0]   dist_r;
  logic [MODE_W-1:0]   mode_r;
  logic [BRIDGE_W-1:0] bridge_r;
  logic [DUTY_W-1:0]   duty_a_r;
  logic [DUTY_W-1:0]   duty_b_r;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   dist_nxt;
  logic [DIST_W-1:0]   d_front;
  logic [DIST_W-1:0]   d_right;
  logic [DIST_W-1:0]   d_left;
  logic                near_f;
  logic                near_r;
  logic                near_l;
  logic [MODE_W-1:0]   mode_nxt;
  logic [BRIDGE_W-1:0] bridge_nxt;
  logic [DUTY_W-1:0]   duty_a_nxt;
  logic [DUTY_W-1:0]   duty_b_nxt;

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  // Scale width by 17 and clamp to the distance range
  always_comb begin
    prod = {{5{1'b0}}, q_data.width} + {1'b0, q_data.width, 4'b0000};
    if (prod > PROD_W'((1 << DIST_W) - 1)) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = DIST_W'(prod);
    end
  end

  // Front distances with the new measurement folded in
  always_comb begin
    d_front = (q_data.ch == CH_FRONT)       ? dist_nxt : last_distance_r[CH_FRONT];
    d_right = (q_data.ch == CH_FRONT_RIGHT) ? dist_nxt : last_distance_r[CH_FRONT_RIGHT];
    d_left  = (q_data.ch == CH_FRONT_LEFT)  ? dist_nxt : last_distance_r[CH_FRONT_LEFT];
    near_f  = d_front < cfg.near_limit;
    near_r  = d_right < cfg.near_limit;
    near_l  = d_left < cfg.near_limit;
  end

  // Priority rule for the drive mode
  always_comb begin
    if (near_f && near_r && near_l) begin
      mode_nxt = MODE_BACK;
    end else if (near_f && near_r) begin
      mode_nxt = MODE_QUICK_LEFT;
    end else if (near_f && near_l) begin
      mode_nxt = MODE_QUICK_RIGHT;
    end else if (near_f) begin
      mode_nxt = MODE_STOP;
    end else if (near_r) begin
      mode_nxt = MODE_SLOW_LEFT;
    end else if (near_l) begin
      mode_nxt = MODE_SLOW_RIGHT;
    end else begin
      mode_nxt = MODE_FORWARD;
    end
  end

  // Decode bridge bits and duties; stop keeps the held duties
  always_comb begin
    duty_a_nxt = cfg.duty_cruise;
    duty_b_nxt = cfg.duty_cruise;
    unique case (mode_nxt)
      MODE_STOP: begin
        bridge_nxt = BRIDGE_STOP;
        duty_a_nxt = held_duty_a_r;
        duty_b_nxt = held_duty_b_r;
      end
      MODE_FORWARD:     bridge_nxt = BRIDGE_FORWARD;
      MODE_BACK:        bridge_nxt = BRIDGE_BACK;
      MODE_SLOW_RIGHT: begin
        bridge_nxt = BRIDGE_FORWARD;
        duty_a_nxt = cfg.duty_high;
        duty_b_nxt = cfg.duty_low;
      end
      MODE_QUICK_RIGHT: bridge_nxt = BRIDGE_QRIGHT;
      MODE_SLOW_LEFT: begin
        bridge_nxt = BRIDGE_FORWARD;
        duty_a_nxt = cfg.duty_low;
        duty_b_nxt = cfg.duty_high;
      end
      default:          bridge_nxt = BRIDGE_QLEFT;
    endcase
  end

  // Steering state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      held_duty_a_r <= '0;
      held_duty_b_r <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        last_distance_r[i] <= '0;
      end
    end else begin
      if (q_pop) begin
        out_valid_r                <= 1'b1;
        held_duty_a_r              <= duty_a_nxt;
        held_duty_b_r              <= duty_b_nxt;
        last_distance_r[q_data.ch] <= dist_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ch_r     <= q_data.ch;
      dist_r   <= dist_nxt;
      mode_r   <= mode_nxt;
      bridge_r <= bridge_nxt;
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_measured_channel = ch_r;
  assign out_distance         = dist_r;
  assign out_drive_mode       = mode_r;
  assign out_bridge_bits      = bridge_r;
  assign out_duty_left        = duty_a_r;
  assign out_duty_right       = duty_b_r;

endmodule

@@ src/ultrasonic_obstacle_steering_top.sv @@
// Top level of the ultrasonic obstacle steering block with its settings registers.
`timescale 1ns / 1ps

// Takes one capture event per cycle while in_stall is low. A rising edge only
// records its stamp and yields no result; a falling edge yields one result on
// the result ports after it passes through the queue and the result register.
// The front end measures the pulse width in the cycle of the transfer and drops
// it into a two-entry queue; the back end scales it, applies the obstacle rule
// and loads the result register. in_stall rises only when that queue is full.
// Write settings only while idle.

module ultrasonic_obstacle_steering_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [usteer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usteer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [usteer_pkg::CH_W-1:0]       in_channel,
  input  logic [usteer_pkg::COUNT_BITS-1:0] in_capture_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [usteer_pkg::CH_W-1:0]       out_measured_channel,
  output logic [usteer_pkg::DIST_W-1:0]     out_distance,
  output logic [usteer_pkg::MODE_W-1:0]     out_drive_mode,
  output logic [usteer_pkg::BRIDGE_W-1:0]   out_bridge_bits,
  output logic [usteer_pkg::DUTY_W-1:0]     out_duty_left,
  output logic [usteer_pkg::DUTY_W-1:0]     out_duty_right
);
  import usteer_pkg::*;

  logic [COUNT_BITS-1:0] counter_top_r;
  steer_cfg_t            steer_cfg_r;
  logic                  push;
  pulse_t                push_data;
  logic                  q_pop;
  pulse_t                q_data;
  logic                  q_not_empty;
  logic                  q_full;

  // Settings registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_top_r           <= RST_COUNTER_TOP;
      steer_cfg_r.near_limit  <= RST_NEAR_LIMIT;
      steer_cfg_r.duty_cruise <= RST_DUTY_CRUISE;
      steer_cfg_r.duty_high   <= RST_DUTY_HIGH;
      steer_cfg_r.duty_low    <= RST_DUTY_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNTER_TOP: counter_top_r           <= cfg_wdata[COUNT_BITS-1:0];
        CFG_NEAR_LIMIT:  steer_cfg_r.near_limit  <= cfg_wdata[DIST_W-1:0];
        CFG_DUTY_CRUISE: steer_cfg_r.duty_cruise <= cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_HIGH:   steer_cfg_r.duty_high   <= cfg_wdata[DUTY_W-1:0];
        CFG_DUTY_LOW:    steer_cfg_r.duty_low    <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  usteer_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (q_full),
    .in_channel       (in_channel),
    .in_capture_count (in_capture_count),
    .counter_top      (counter_top_r),
    .push             (push),
    .push_data        (push_data)
  );

  usteer_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  usteer_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (steer_cfg_r),
    .q_not_empty          (q_not_empty),
    .q_data               (q_data),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_measured_channel (out_measured_channel),
    .out_distance         (out_distance),
    .out_drive_mode       (out_drive_mode),
    .out_bridge_bits      (out_bridge_bits),
    .out_duty_left        (out_duty_left),
    .out_duty_right       (out_duty_right)
  );

endmodule
